@@ design/tlql_pkg.sv @@
// ----------------------------------------------------------------------------
// tlql_pkg
// Shared types and constants of the text line quad layout unit.
// ----------------------------------------------------------------------------
package tlql_pkg;

  localparam int unsigned LINE_QUADS = 64;
  localparam int unsigned CNT_W = $clog2(LINE_QUADS + 1);
  localparam int unsigned IDX_W = (LINE_QUADS > 1) ? $clog2(LINE_QUADS) : 1;

  localparam int unsigned CELL_W  = 16;
  localparam int unsigned CELL_H  = 10;
  localparam int unsigned U_OFF   = 2;
  localparam int unsigned V_OFF   = 1;
  localparam int unsigned GLYPH_H = 9;
  localparam int unsigned BAND_H  = 160;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned VH_W    = 12;
  localparam logic [PADDR_W-3:0] REG_VIEWPORT = '0;
  localparam logic [VH_W-1:0]    VIEWPORT_RESET = 12'd480;

  localparam logic       OP_WRITE = 1'b0;
  localparam logic       OP_TEXT  = 1'b1;
  localparam logic [7:0] CODE_EOT = 8'd0;
  localparam logic [7:0] CODE_NL  = 8'd10;

  typedef struct packed {
    logic [15:0] xl;
    logic [15:0] xr;
    logic [7:0]  code;
    logic [3:0]  w;
    logic [1:0]  color;
    logic [3:0]  scale;
  } line_entry_t;

  typedef struct packed {
    logic ready;
    logic process;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic accepted;
    logic emit_start;
    logic issue_last;
  } dp_status_t;

endpackage

@@ design/tlql_if.sv @@
// ----------------------------------------------------------------------------
// tlql_if
// Request channels of the text line quad layout unit: characters in, quads out.
// ----------------------------------------------------------------------------
interface tlql_item_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [7:0]         code;
  logic [3:0]         glyph_width;
  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic [3:0]         scale;
  logic [1:0]         color;
  logic               center;

  modport source (output valid, operation, code, glyph_width, origin_x, origin_y,
                  scale, color, center, input ready);
  modport sink (input valid, operation, code, glyph_width, origin_x, origin_y,
                scale, color, center, output ready);
endinterface

interface tlql_quad_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_left;
  logic signed [15:0] x_right;
  logic signed [15:0] y_low;
  logic signed [15:0] y_high;
  logic [8:0]         u_left;
  logic [8:0]         u_right;
  logic [9:0]         v_at_low;
  logic [9:0]         v_at_high;
  logic               last;
  logic               end_of_text;
  logic               line_overflow;

  modport source (output valid, x_left, x_right, y_low, y_high, u_left, u_right,
                  v_at_low, v_at_high, last, end_of_text, line_overflow, input ready);
  modport sink (input valid, x_left, x_right, y_low, y_high, u_left, u_right,
                v_at_low, v_at_high, last, end_of_text, line_overflow, output ready);
endinterface

@@ design/tlql_ctrl.sv @@
// ----------------------------------------------------------------------------
// tlql_ctrl
// Sequencer: take a request, process it, then stream out a finished line when the request ends a non-empty line.
// ----------------------------------------------------------------------------
module tlql_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  tlql_pkg::dp_status_t st,
  output tlql_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_PROC = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (st.accepted) begin
          state_next = ST_PROC;
        end
      end
      ST_PROC: begin
        cmd.process = 1'b1;
        state_next  = st.emit_start ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (st.issue_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/tlql_dpath.sv @@
// ----------------------------------------------------------------------------
// tlql_dpath
// Width table, pen state, line store and the quad output pipeline.
// ----------------------------------------------------------------------------
module tlql_dpath (
  input  logic                         clk,
  input  logic                         rst,
  input  tlql_pkg::ctrl_cmd_t          cmd,
  output tlql_pkg::dp_status_t         st,
  input  logic [tlql_pkg::VH_W-1:0]    viewport_height,
  tlql_item_if.sink                    item,
  tlql_quad_if.source                  quad
);

  // captured request
  logic        it_op;
  logic [7:0]  it_code;
  logic [3:0]  it_gw;
  logic [15:0] it_ox;
  logic [15:0] it_oy;
  logic [3:0]  it_scale;
  logic [1:0]  it_color;
  logic        it_center;

  // width table
  logic [3:0] wt_mem [256];
  logic [255:0] wt_valid;
  logic [3:0] wt_q;
  logic       wt_vq;

  // pen and line state
  logic [15:0]               pen_x;
  logic [15:0]               pen_y;
  logic                      text_start;
  logic [tlql_pkg::CNT_W-1:0] cnt;
  logic                      dropped;
  logic [15:0]               first_x;

  // line store
  tlql_pkg::line_entry_t line_mem [tlql_pkg::LINE_QUADS];

  // emission state
  logic [tlql_pkg::CNT_W-1:0] em_cnt;
  logic [tlql_pkg::CNT_W-1:0] em_idx;
  logic [15:0]               em_delta;
  logic [15:0]               em_y;
  logic                      em_eot;
  logic                      em_ovf;

  // read stage
  tlql_pkg::line_entry_t q_data;
  logic                  q_valid;
  logic                  q_last;
  logic                  q_eot;
  logic                  q_ovf;
  logic [15:0]           q_delta;
  logic [15:0]           q_y;

  // output register
  logic        o_valid;
  logic [15:0] o_xl, o_xr, o_yl, o_yh;
  logic [8:0]  o_ul, o_ur;
  logic [9:0]  o_vl, o_vh;
  logic        o_last, o_eot, o_ovf;

  logic        accept;
  logic [3:0]  w_eff;
  logic [7:0]  s9;
  logic [7:0]  wsc;
  logic [15:0] py_start;
  logic [15:0] px_eff;
  logic [15:0] py_eff;
  logic [15:0] xr_new;
  logic        is_glyph;
  logic        full;
  logic [16:0] mid_sum;
  logic [16:0] mid_adj;
  logic [15:0] delta;
  logic        issue;
  logic        adv_b;
  tlql_pkg::line_entry_t entry;

  logic [7:0]  q_s9;
  logic [8:0]  q_ul;
  logic [9:0]  q_vh;

  assign item.ready = cmd.ready && !rst;
  assign accept     = item.valid && item.ready;

  // processing of a captured request
  always_comb begin
    w_eff    = wt_vq ? wt_q : 4'd0;
    s9       = 8'(it_scale) * 8'(tlql_pkg::GLYPH_H);
    wsc      = 8'(w_eff) * 8'(it_scale);
    py_start = 16'(viewport_height) - it_oy - 16'(s9);
    px_eff   = text_start ? it_ox : pen_x;
    py_eff   = text_start ? py_start : pen_y;
    xr_new   = px_eff + 16'(wsc);
    is_glyph = (it_code != tlql_pkg::CODE_NL) && (it_code != tlql_pkg::CODE_EOT);
    full     = (cnt == tlql_pkg::CNT_W'(tlql_pkg::LINE_QUADS));
    // truncating midpoint of the line span
    mid_sum  = {first_x[15], first_x} + {px_eff[15], px_eff};
    mid_adj  = mid_sum + {16'd0, mid_sum[16]};
    delta    = it_ox - mid_adj[16:1];
    entry.xl    = px_eff;
    entry.xr    = xr_new;
    entry.code  = it_code;
    entry.w     = w_eff;
    entry.color = it_color;
    entry.scale = it_scale;
  end

  assign st.accepted   = accept;
  assign st.emit_start = cmd.process && (it_op == tlql_pkg::OP_TEXT) && !is_glyph
                         && (cnt != '0);
  assign adv_b         = q_valid && (!o_valid || quad.ready);
  assign issue         = cmd.emit && (em_idx != em_cnt) && (!q_valid || adv_b);
  assign st.issue_last = issue && ((em_idx + 1'b1) == em_cnt);

  always_ff @(posedge clk) begin
    if (accept) begin
      it_op     <= item.operation;
      it_code   <= item.code;
      it_gw     <= item.glyph_width;
      it_ox     <= item.origin_x;
      it_oy     <= item.origin_y;
      it_scale  <= item.scale;
      it_color  <= item.color;
      it_center <= item.center;
    end
  end

  // width table memory
  always_ff @(posedge clk) begin
    if (cmd.process && it_op == tlql_pkg::OP_WRITE) begin
      wt_mem[it_code] <= it_gw;
    end
    if (accept) begin
      wt_q <= wt_mem[item.code];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wt_valid <= '0;
      wt_vq    <= 1'b0;
    end else begin
      if (cmd.process && it_op == tlql_pkg::OP_WRITE) begin
        wt_valid[it_code] <= 1'b1;
      end
      if (accept) begin
        wt_vq <= wt_valid[item.code];
      end
    end
  end

  // line store memory
  always_ff @(posedge clk) begin
    if (cmd.process && it_op == tlql_pkg::OP_TEXT && is_glyph && !full) begin
      line_mem[cnt[tlql_pkg::IDX_W-1:0]] <= entry;
    end
    if (issue) begin
      q_data <= line_mem[em_idx[tlql_pkg::IDX_W-1:0]];
    end
  end

  // pen and line state
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x      <= '0;
      pen_y      <= '0;
      text_start <= 1'b1;
      cnt        <= '0;
      dropped    <= 1'b0;
      em_cnt     <= '0;
      em_idx     <= '0;
    end else if (cmd.process && it_op == tlql_pkg::OP_TEXT) begin
      text_start <= 1'b0;
      if (is_glyph) begin
        pen_y <= py_eff;
        if (full) begin
          dropped <= 1'b1;
          pen_x   <= px_eff;
        end else begin
          pen_x <= xr_new;
          cnt   <= cnt + 1'b1;
        end
      end else begin
        em_cnt     <= cnt;
        em_idx     <= '0;
        pen_x      <= it_ox;
        pen_y      <= py_eff - 16'(s9);
        cnt        <= '0;
        dropped    <= 1'b0;
        text_start <= (it_code == tlql_pkg::CODE_EOT);
      end
    end else if (issue) begin
      em_idx <= em_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.process && it_op == tlql_pkg::OP_TEXT) begin
      if (is_glyph && !full && cnt == '0) begin
        first_x <= px_eff;
      end
      if (!is_glyph) begin
        em_delta <= it_center ? delta : 16'd0;
        em_y     <= py_eff;
        em_eot   <= (it_code == tlql_pkg::CODE_EOT);
        em_ovf   <= dropped;
      end
    end
    if (issue) begin
      q_last  <= ((em_idx + 1'b1) == em_cnt);
      q_eot   <= em_eot;
      q_ovf   <= em_ovf;
      q_delta <= em_delta;
      q_y     <= em_y;
    end
  end

  // quad conversion into the output register
  always_comb begin
    q_s9 = 8'(q_data.scale) * 8'(tlql_pkg::GLYPH_H);
    q_ul = 9'(q_data.code[3:0]) * 9'(tlql_pkg::CELL_W) + 9'(tlql_pkg::U_OFF);
    q_vh = 10'(q_data.code[7:4]) * 10'(tlql_pkg::CELL_H) + 10'(tlql_pkg::V_OFF)
           + 10'(q_data.color) * 10'(tlql_pkg::BAND_H);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (issue) begin
        q_valid <= 1'b1;
      end else if (adv_b) begin
        q_valid <= 1'b0;
      end
      if (adv_b) begin
        o_valid <= 1'b1;
      end else if (quad.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      o_xl   <= q_data.xl + q_delta;
      o_xr   <= q_data.xr + q_delta;
      o_yl   <= q_y;
      o_yh   <= q_y + 16'(q_s9);
      o_ul   <= q_ul;
      o_ur   <= q_ul + 9'(q_data.w);
      o_vh   <= q_vh;
      o_vl   <= q_vh + 10'(tlql_pkg::GLYPH_H);
      o_last <= q_last;
      o_eot  <= q_eot;
      o_ovf  <= q_ovf;
    end
  end

  assign quad.valid         = o_valid;
  assign quad.x_left        = o_xl;
  assign quad.x_right       = o_xr;
  assign quad.y_low         = o_yl;
  assign quad.y_high        = o_yh;
  assign quad.u_left        = o_ul;
  assign quad.u_right       = o_ur;
  assign quad.v_at_low      = o_vl;
  assign quad.v_at_high     = o_vh;
  assign quad.last          = o_last;
  assign quad.end_of_text   = o_eot;
  assign quad.line_overflow = o_ovf;

endmodule

@@ design/text_line_quad_layout_unit.sv @@
// ----------------------------------------------------------------------------
// text_line_quad_layout_unit
// Lays out characters as atlas quads, buffering a line and emitting it at
// newline or end of text, optionally centered on the origin.
//
//   channel  direction  handshake            carries
//   item     in         valid / ready        one character or width write
//   quad     out        valid / ready        one screen quad of a line
//   apb      in         psel/penable/pready  viewport_height at address 0
//
// each request is captured with the width table read, then processed; a
// line end then streams one quad per cycle, while the quad sink is ready,
// from the line store through a read stage and an output register
// a stalled quad holds the output register; requests wait until the line
// has been read out of the store
// reset is synchronous; the width table valid bits clear at once, no sweep
// ----------------------------------------------------------------------------
module text_line_quad_layout_unit (
  input  logic                            clk,
  input  logic                            rst,
  tlql_item_if.sink                       item,
  tlql_quad_if.source                     quad,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tlql_pkg::PADDR_W-1:0]    paddr,
  input  logic [tlql_pkg::PDATA_W-1:0]    pwdata,
  output logic [tlql_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  tlql_pkg::ctrl_cmd_t  cmd;
  tlql_pkg::dp_status_t st;
  logic [tlql_pkg::VH_W-1:0] viewport_height;
  logic sel_vh;

  assign pready = 1'b1;
  assign sel_vh = (paddr[tlql_pkg::PADDR_W-1:2] == tlql_pkg::REG_VIEWPORT);
  assign prdata = sel_vh ? tlql_pkg::PDATA_W'(viewport_height) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      viewport_height <= tlql_pkg::VIEWPORT_RESET;
    end else if (psel && penable && pwrite && pready && sel_vh) begin
      viewport_height <= pwdata[tlql_pkg::VH_W-1:0];
    end
  end

  tlql_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  tlql_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .viewport_height (viewport_height),
    .item            (item),
    .quad            (quad)
  );

`ifndef SYNTHESIS
  a_accept_then_process: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> (cmd.process && !item.ready))
    else $error("accepted request not processed next cycle");

  a_no_ready_while_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !item.ready)
    else $error("request taken while line store is read out");

  a_last_issue_ends_emit: assert property (@(posedge clk) disable iff (rst)
    st.issue_last |=> !cmd.emit)
    else $error("readout continues past the last quad");
`endif

endmodule
